/* rtl/bitmap_run_block_allocator_defines.svh */
// assertion macros for the bitmap run block allocator
// included by the top level, needs nothing else
`ifndef BITMAP_RUN_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_RUN_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BMRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bmra_pkg.sv */
// shared types, codes and width helpers for the bitmap run block allocator
// no dependencies
package bmra_pkg;

    localparam int DEF_MAX_BLOCKS = 256;
    localparam int BLK_CFG_W      = 9;
    localparam int START_W        = 8;
    localparam int COUNT_W        = 9;
    localparam int STATUS_W       = 2;
    localparam int WORD_BITS      = 8;
    localparam int WORD_SHIFT     = 3;

    localparam logic [BLK_CFG_W-1:0] CFG_RESET = 9'd256;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_NOROOM = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef struct packed {
        logic init;
        logic step;
    } t_scan_ctl;

    typedef struct packed {
        logic found;
    } t_scan_sts;

    function automatic int word_count(input int max_blocks);
        return (max_blocks + WORD_BITS - 1) / WORD_BITS;
    endfunction

    function automatic int addr_width(input int max_blocks);
        int wc;
        wc = word_count(max_blocks);
        return (wc > 1) ? $clog2(wc) : 1;
    endfunction

    // holds any block position, block count, run end and start + count
    function automatic int pos_width(input int max_blocks);
        int aw;
        aw = addr_width(max_blocks) + WORD_SHIFT;
        return ((aw > COUNT_W) ? aw : COUNT_W) + 1;
    endfunction

endpackage

/* rtl/bmra_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bmra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/bmra_scan.sv */
// first-fit run finder, eats one map word per step
// depends on bmra_pkg
module bmra_scan import bmra_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_scan_ctl                        i_ctl,
    input  logic [WORD_BITS-1:0]             i_word,
    input  logic [pos_width(MAX_BLOCKS)-1:0] i_word_base,
    input  logic [pos_width(MAX_BLOCKS)-1:0] i_count,
    input  logic [pos_width(MAX_BLOCKS)-1:0] i_limit,
    output t_scan_sts                        o_sts,
    output logic [pos_width(MAX_BLOCKS)-1:0] o_run_begin
);

    localparam int XW = pos_width(MAX_BLOCKS);

    logic [XW-1:0] r_len;
    logic [XW-1:0] r_beg;
    logic          r_found;
    logic [XW-1:0] n_len;
    logic [XW-1:0] n_beg;
    logic          n_found;

    // walk the eight bits in order, stop counting once the run is long enough
    always_comb begin
        logic [XW-1:0] pos;
        n_len   = r_len;
        n_beg   = r_beg;
        n_found = r_found;
        for (int b = 0; b < WORD_BITS; b++) begin
            pos = i_word_base + XW'(b);
            if (!n_found && (pos < i_limit)) begin
                if (!i_word[b]) begin
                    if (n_len == '0) begin
                        n_beg = pos;
                    end
                    n_len = n_len + 1'b1;
                    if (n_len == i_count) begin
                        n_found = 1'b1;
                    end
                end else begin
                    n_len = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_found <= 1'b0;
        end else if (i_ctl.init) begin
            r_len   <= '0;
            r_found <= 1'b0;
        end else if (i_ctl.step) begin
            r_len   <= n_len;
            r_found <= n_found;
        end
        if (i_ctl.step) begin
            r_beg <= n_beg;
        end
    end

    assign o_sts.found = r_found;
    assign o_run_begin = r_beg;

endmodule

/* rtl/bitmap_run_block_allocator.sv */
// bitmap run block allocator top level: control, read-modify-write, result register
// depends on bmra_pkg, bmra_ram, bmra_scan and the assertion macro header
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   i_kind, i_start_block, i_count
//  result    out        o_out_valid / i_out_stall o_status, o_run_start
//  config    in         i_cfg_wr_en               i_cfg_wr_data (managed blocks)
//
// one item at a time; the map is held eight blocks per ram word
// rejected items and zero-count frees go straight to the response state; a free reads and
// rewrites each word it touches; an allocate scans from word zero and on a hit reads and
// rewrites the words of the run; the result register loads from the response state
// once the output is free; after reset a clearing pass zeroes every map word, requests stalled
// a stalled result sits in the output register while the next item is taken
`include "bitmap_run_block_allocator_defines.svh"

module bitmap_run_block_allocator import bmra_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_kind,
    input  logic [START_W-1:0]   i_start_block,
    input  logic [COUNT_W-1:0]   i_count,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [START_W-1:0]   o_run_start,
    input  logic                 i_cfg_wr_en,
    input  logic [BLK_CFG_W-1:0] i_cfg_wr_data
);

    localparam int WORDS = word_count(MAX_BLOCKS);
    localparam int AW    = addr_width(MAX_BLOCKS);
    localparam int XW    = pos_width(MAX_BLOCKS);

    localparam logic [XW-1:0] MAX_POS = XW'(MAX_BLOCKS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RANGE,
        S_RESP
    } t_state;

    t_state               r_state,      n_state;
    logic [BLK_CFG_W-1:0] r_cfg;
    logic                 r_mark,       n_mark;
    logic [XW-1:0]        r_count,      n_count;
    logic [XW-1:0]        r_lo,         n_lo;
    logic [XW-1:0]        r_hi,         n_hi;
    logic [AW-1:0]        r_addr,       n_addr;
    logic [AW-1:0]        r_last,       n_last;
    logic [AW-1:0]        r_daddr,      n_daddr;
    logic                 r_more,       n_more;
    logic                 r_pend,       n_pend;
    t_status              r_res_status, n_res_status;
    logic [START_W-1:0]   r_res_start,  n_res_start;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [START_W-1:0]   r_out_start;

    logic [XW-1:0]        cfg_x;
    logic [XW-1:0]        lim;
    logic [XW-1:0]        lim_m1;
    logic [XW-1:0]        in_start;
    logic [XW-1:0]        in_count;
    logic [XW-1:0]        in_end;
    logic [XW-1:0]        in_end_m1;
    logic [XW-1:0]        run_begin;
    logic [XW-1:0]        run_end;
    logic [XW-1:0]        run_end_m1;
    logic [XW-1:0]        word_base;
    logic                 in_acc;
    logic                 out_free;
    logic                 out_load;

    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;
    logic [WORD_BITS-1:0] merged;

    t_scan_ctl            scan_ctl;
    t_scan_sts            scan_sts;

    bmra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    bmra_scan #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_word      (ram_rd_data),
        .i_word_base (word_base),
        .i_count     (r_count),
        .i_limit     (lim),
        .o_sts       (scan_sts),
        .o_run_begin (run_begin)
    );

    // managed size never exceeds the pool
    assign cfg_x      = XW'(r_cfg);
    assign lim        = (cfg_x > MAX_POS) ? MAX_POS : cfg_x;
    assign lim_m1     = lim - 1'b1;
    assign in_start   = XW'(i_start_block);
    assign in_count   = XW'(i_count);
    assign in_end     = in_start + in_count;
    assign in_end_m1  = in_end - 1'b1;
    assign run_end    = run_begin + r_count;
    assign run_end_m1 = run_end - 1'b1;
    assign word_base  = XW'({r_daddr, WORD_SHIFT'(0)});

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == S_RESP) && out_free;

    assign ram_rd_addr = r_addr;

    // set or clear the bits of the returning word that fall in [lo, hi)
    always_comb begin
        logic [XW-1:0] pos;
        for (int b = 0; b < WORD_BITS; b++) begin
            pos = word_base + XW'(b);
            merged[b] = ((pos >= r_lo) && (pos < r_hi)) ? r_mark : ram_rd_data[b];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_mark       = r_mark;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_addr       = r_addr;
        n_last       = r_last;
        n_daddr      = r_daddr;
        n_more       = r_more;
        n_pend       = r_pend;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_daddr;
        ram_wr_data  = merged;
        ram_rd_en    = 1'b0;
        scan_ctl     = '0;

        unique case (r_state)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_addr;
                ram_wr_data = '0;
                n_addr      = r_addr + 1'b1;
                if (r_addr == AW'(WORDS - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    scan_ctl.init = 1'b1;
                    n_pend        = 1'b0;
                    n_more        = 1'b1;
                    n_count       = in_count;
                    n_res_start   = '0;
                    n_res_status  = ST_DONE;
                    if (i_kind == KIND_FREE) begin
                        n_mark = 1'b0;
                        n_lo   = in_start;
                        n_hi   = in_end;
                        n_addr = in_start[AW+WORD_SHIFT-1:WORD_SHIFT];
                        n_last = in_end_m1[AW+WORD_SHIFT-1:WORD_SHIFT];
                        if (in_end > lim) begin
                            n_res_status = ST_RANGE;
                            n_state      = S_RESP;
                        end else if (in_count == '0) begin
                            n_state = S_RESP;
                        end else begin
                            n_state = S_RANGE;
                        end
                    end else begin
                        n_mark = 1'b1;
                        n_addr = '0;
                        n_last = lim_m1[AW+WORD_SHIFT-1:WORD_SHIFT];
                        if (in_count == '0) begin
                            n_res_status = ST_RANGE;
                            n_state      = S_RESP;
                        end else if (in_count > lim) begin
                            n_res_status = ST_NOROOM;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                ram_rd_en     = r_more;
                scan_ctl.step = r_pend;
                n_pend        = r_more;
                if (r_more) begin
                    n_addr  = r_addr + 1'b1;
                    n_daddr = r_addr;
                    n_more  = (r_addr != r_last);
                end
                // a read still in flight after the hit is simply dropped
                if (scan_sts.found) begin
                    ram_rd_en   = 1'b0;
                    n_lo        = run_begin;
                    n_hi        = run_end;
                    n_addr      = run_begin[AW+WORD_SHIFT-1:WORD_SHIFT];
                    n_last      = run_end_m1[AW+WORD_SHIFT-1:WORD_SHIFT];
                    n_more      = 1'b1;
                    n_pend      = 1'b0;
                    n_res_start = run_begin[START_W-1:0];
                    n_state     = S_RANGE;
                end else if (!r_more && !r_pend) begin
                    n_res_status = ST_NOROOM;
                    n_state      = S_RESP;
                end
            end
            S_RANGE: begin
                // read word k+1 while word k is written back
                ram_rd_en = r_more;
                ram_wr_en = r_pend;
                n_pend    = r_more;
                if (r_more) begin
                    n_addr  = r_addr + 1'b1;
                    n_daddr = r_addr;
                    n_more  = (r_addr != r_last);
                end
                if (!r_more && !r_pend) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cfg       <= CFG_RESET;
            r_addr      <= '0;
            r_more      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_more  <= n_more;
            r_pend  <= n_pend;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_mark       <= n_mark;
        r_count      <= n_count;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_last       <= n_last;
        r_daddr      <= n_daddr;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_start  <= r_res_start;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_run_start = r_out_start;

    `BMRA_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "map read and write hit the same word")
    `BMRA_ASSERT_IMP(a_clear_stalls, i_clk, i_rst_n, r_state == S_CLEAR, ram_wr_en && o_in_stall, "clearing pass must write and stall requests")
    `BMRA_ASSERT_NXT(a_hit_marks, i_clk, i_rst_n, (r_state == S_SCAN) && scan_sts.found, (r_state == S_RANGE) && r_mark, "found run not marked")
    `BMRA_ASSERT_NXT(a_load_from_resp, i_clk, i_rst_n, (r_state != S_RESP) && !r_out_valid, !r_out_valid, "result loaded outside response state")

endmodule

/* tb/bitmap_run_block_allocator_test.sv */
// self-checking testbench for the bitmap run block allocator
// holds its own occupancy map predictor; needs bmra_pkg and bitmap_run_block_allocator
`timescale 1ns / 1ps

module bitmap_run_block_allocator_test;
    import bmra_pkg::*;

    localparam int RUN_LIMIT  = 1000000;
    localparam int DRAIN_WAIT = 200;

    typedef struct {
        t_status            status;
        logic [START_W-1:0] run_start;
    } answer_t;

    typedef struct {
        int first;
        int len;
    } live_run_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_kind;
    logic [START_W-1:0]   i_start_block;
    logic [COUNT_W-1:0]   i_count;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [STATUS_W-1:0]  o_status;
    logic [START_W-1:0]   o_run_start;
    logic                 i_cfg_wr_en;
    logic [BLK_CFG_W-1:0] i_cfg_wr_data;

    // predictor state
    logic [DEF_MAX_BLOCKS-1:0] busy_map;
    logic [BLK_CFG_W-1:0]      pool_size;

    answer_t   answers_due[$];
    live_run_t live_runs[$];

    int errors      = 0;
    int cycle_count = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_len    = 0;

    bitmap_run_block_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_start_block (i_start_block),
        .i_count       (i_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_run_start   (o_run_start),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // first-fit allocate or range free on the predicted map
    function automatic answer_t predict_answer(t_kind kind, logic [START_W-1:0] start,
                                               logic [COUNT_W-1:0] count);
        answer_t ans;
        int      n;
        int      run_begin;
        int      run_len;
        bit      found;
        ans.status    = ST_DONE;
        ans.run_start = '0;
        n         = (pool_size > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(pool_size);
        run_begin = 0;
        run_len   = 0;
        found     = 1'b0;
        if (kind == KIND_ALLOC) begin
            if (count == 0) begin
                ans.status = ST_RANGE;
            end else begin
                for (int i = 0; i < n && !found; i++) begin
                    if (!busy_map[i]) begin
                        if (run_len == 0)
                            run_begin = i;
                        run_len++;
                        if (run_len == int'(count))
                            found = 1'b1;
                    end else begin
                        run_len = 0;
                    end
                end
                if (!found) begin
                    ans.status = ST_NOROOM;
                end else begin
                    for (int i = 0; i < int'(count); i++)
                        busy_map[run_begin + i] = 1'b1;
                    ans.run_start = START_W'(run_begin);
                end
            end
        end else if (int'(start) + int'(count) > n) begin
            ans.status = ST_RANGE;
        end else begin
            for (int i = 0; i < int'(count); i++)
                busy_map[int'(start) + i] = 1'b0;
        end
        return ans;
    endfunction

    // result checker
    always @(posedge i_clk) begin : check_result
        answer_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, got status %0d run_start %0d",
                         $time, o_status, o_run_start);
            end else begin
                want = answers_due.pop_front();
                if (o_status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d got %0d", $time, want.status, o_status);
                end
                if (o_run_start !== want.run_start) begin
                    errors++;
                    $display("%0t: run_start expected %0d got %0d",
                             $time, want.run_start, o_run_start);
                end
            end
        end
    end

    // result side stall: random, or one long hold counted here
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_item(input t_kind kind, input logic [START_W-1:0] start,
                             input logic [COUNT_W-1:0] count, output answer_t ans);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_start_block <= start;
        i_count       <= count;
        do @(posedge i_clk); while (o_in_stall);
        ans = predict_answer(kind, start, count);
        answers_due.push_back(ans);
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_pool_size(input logic [BLK_CFG_W-1:0] size);
        stop_sending();
        while (answers_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= size;
        @(posedge i_clk);
        pool_size = size;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic test_full_pool_extremes();
        answer_t a;
        send_item(KIND_ALLOC, 8'd0,   9'd0,   a);
        send_item(KIND_ALLOC, 8'd0,   9'd1,   a);
        send_item(KIND_ALLOC, 8'd0,   9'd256, a);
        send_item(KIND_ALLOC, 8'd0,   9'd255, a);
        send_item(KIND_ALLOC, 8'd0,   9'd1,   a);
        send_item(KIND_FREE,  8'd255, 9'd1,   a);
        send_item(KIND_FREE,  8'd255, 9'd2,   a);
        send_item(KIND_FREE,  8'd255, 9'd0,   a);
        send_item(KIND_FREE,  8'd0,   9'd256, a);
        // freeing blocks that are already free
        send_item(KIND_FREE,  8'd0,   9'd256, a);
        send_item(KIND_ALLOC, 8'd255, 9'd256, a);
        send_item(KIND_FREE,  8'd0,   9'd256, a);
    endtask

    task automatic test_single_block();
        answer_t a;
        set_pool_size(9'd1);
        send_item(KIND_ALLOC, 8'd0, 9'd1, a);
        send_item(KIND_ALLOC, 8'd0, 9'd2, a);
        send_item(KIND_FREE,  8'd1, 9'd0, a);
        send_item(KIND_FREE,  8'd2, 9'd0, a);
        send_item(KIND_FREE,  8'd0, 9'd1, a);
    endtask

    // blocks above a shrunk size stay busy and come back when it grows
    task automatic test_shrink_keeps_map();
        answer_t a;
        set_pool_size(9'd256);
        send_item(KIND_ALLOC, 8'd0,  9'd100, a);
        set_pool_size(9'd50);
        send_item(KIND_ALLOC, 8'd0,  9'd1,   a);
        send_item(KIND_FREE,  8'd40, 9'd20,  a);
        set_pool_size(9'd256);
        send_item(KIND_ALLOC, 8'd0,  9'd1,   a);
        send_item(KIND_FREE,  8'd0,  9'd101, a);
    endtask

    task automatic test_degenerate_sizes();
        answer_t a;
        set_pool_size(9'd0);
        send_item(KIND_ALLOC, 8'd0, 9'd5, a);
        send_item(KIND_FREE,  8'd0, 9'd1, a);
        send_item(KIND_FREE,  8'd0, 9'd0, a);
        // size above the pool is clamped to the pool
        set_pool_size(9'd511);
        send_item(KIND_ALLOC, 8'd0, 9'd256, a);
        send_item(KIND_FREE,  8'd0, 9'd256, a);
    endtask

    // mostly allocs and frees of live runs, some stray frees and zero counts
    task automatic random_requests(input int items);
        answer_t   a;
        live_run_t r;
        int        pick;
        int        idx;
        int        cnt;
        repeat (items) begin
            pick = $urandom_range(99);
            if (pick < 38 && live_runs.size() != 0) begin
                idx = $urandom_range(live_runs.size() - 1);
                r = live_runs[idx];
                live_runs.delete(idx);
                send_item(KIND_FREE, START_W'(r.first), COUNT_W'(r.len), a);
                if (a.status == ST_RANGE)
                    live_runs.push_back(r);
            end else if (pick < 92) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    cnt = $urandom_range(8, 1);
                else if (pick < 95)
                    cnt = $urandom_range(64, 9);
                else
                    cnt = $urandom_range(256, 65);
                send_item(KIND_ALLOC, START_W'($urandom_range(255)), COUNT_W'(cnt), a);
                if (a.status == ST_DONE) begin
                    r.first = a.run_start;
                    r.len   = cnt;
                    live_runs.push_back(r);
                end
            end else if ($urandom_range(1)) begin
                cnt = $urandom_range(1) ? $urandom_range(16) : $urandom_range(256);
                send_item(KIND_FREE, START_W'($urandom_range(255)), COUNT_W'(cnt), a);
            end else begin
                send_item(KIND_ALLOC, START_W'($urandom_range(255)), '0, a);
            end
        end
    endtask

    task automatic test_random_traffic();
        gap_pct   = 16;
        stall_pct = 50;
        set_pool_size(9'd256);
        random_requests(80);
        set_pool_size(BLK_CFG_W'($urandom_range(256, 1)));
        random_requests(80);
        gap_pct   = 50;
        stall_pct = 16;
        set_pool_size(9'd256);
        random_requests(80);
        set_pool_size(BLK_CFG_W'($urandom_range(256, 1)));
        random_requests(80);
        gap_pct   = 0;
        stall_pct = 0;
        set_pool_size(9'd8);
        random_requests(80);
        set_pool_size(9'd256);
        random_requests(80);
    endtask

    // result side held off long enough that the block backs up into its input
    task automatic test_backpressure();
        gap_pct   = 0;
        stall_pct = 0;
        hold_len  = 400;
        random_requests(10);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_kind        <= KIND_ALLOC;
        i_start_block <= '0;
        i_count       <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        busy_map  = '0;
        pool_size = CFG_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_pool_extremes();
        test_single_block();
        test_shrink_keeps_map();
        test_degenerate_sizes();
        test_random_traffic();
        test_backpressure();

        stop_sending();
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
